@@ hw/rtl/dielectric_fresnel_reflectance_core_assert.svh @@
// Assertion macros for the checker file of this block.
`ifndef DIELECTRIC_FRESNEL_REFLECTANCE_CORE_ASSERT_SVH
`define DIELECTRIC_FRESNEL_REFLECTANCE_CORE_ASSERT_SVH

// Property that must hold at every edge out of reset.
`define DFR_ASSERT(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define DFR_ASSERT_NEXT(label, pre, post, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

@@ hw/rtl/dfr_pkg.sv @@
package dfr_pkg;

	localparam int FRAC_BITS_OUT_DEF = 16;

	localparam int COS_W = 16;
	localparam int IDX_W = 16;
	localparam int MAG_W = 15;
	localparam logic [MAG_W-1:0] ONE_Q14 = 15'd16384;
	localparam int Q28 = 28;

	localparam int AA_W   = 30;
	localparam int S2I_W  = 29;
	localparam int SQ_W   = 32;
	localparam int LHS_W  = 61;
	localparam int S2T_W  = 28;

	localparam int ROOT_W     = 17;
	localparam int SQRT_REM_W = 19;
	localparam int SQRT_NUM_W = 34;

	localparam int CI_W    = 17;
	localparam int PROD_W  = 33;
	localparam int DEN_W   = 34;
	localparam int RATIO_W = 29;
	localparam int RSQ_W   = 58;
	localparam int SUM_W   = 59;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [IDX_W-1:0] INDEX_RESET = 16'd4096;

	typedef enum logic {
		REG_INCIDENT    = 1'b0,
		REG_TRANSMITTED = 1'b1
	} cfg_reg_t;

	// Data that rides along the quotient and root cells
	typedef struct packed {
		logic             vld;
		logic             tir;
		logic [MAG_W-1:0] mag;
		logic [IDX_W-1:0] n1;
		logic [IDX_W-1:0] n2;
	} front_side_t;

endpackage

@@ hw/rtl/dfr_div_cell.sv @@
module dfr_div_cell #(
	parameter int DW = 32,
	parameter int NW = 28,
	parameter int QW = 28,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [DW-1:0] den_in,
	input  logic [DW-1:0] rem_in,
	input  logic [NW-1:0] num_in,
	input  logic [QW-1:0] quot_in,
	input  logic [SW-1:0] side_in,
	output logic [DW-1:0] den_out,
	output logic [DW-1:0] rem_out,
	output logic [NW-1:0] num_out,
	output logic [QW-1:0] quot_out,
	output logic [SW-1:0] side_out
);

	logic [DW:0]   trial;
	logic          ge;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] num_q;
	logic [QW-1:0] quot_q;
	logic [SW-1:0] side_q;

	// One restoring step: bring in the next dividend bit, subtract if it fits
	assign trial = {rem_in, num_in[NW-1]};
	assign ge    = trial >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q  <= den_in;
			rem_q  <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
			num_q  <= {num_in[NW-2:0], 1'b0};
			quot_q <= {quot_in[QW-2:0], ge};
		end
	end

	assign den_out  = den_q;
	assign rem_out  = rem_q;
	assign num_out  = num_q;
	assign quot_out = quot_q;
	assign side_out = side_q;

endmodule

@@ hw/rtl/dfr_sqrt_cell.sv @@
module dfr_sqrt_cell #(
	parameter int RW  = 19,
	parameter int RTW = 17,
	parameter int NW  = 34,
	parameter int SW  = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [RW-1:0]  rem_in,
	input  logic [RTW-1:0] root_in,
	input  logic [NW-1:0]  num_in,
	input  logic [SW-1:0]  side_in,
	output logic [RW-1:0]  rem_out,
	output logic [RTW-1:0] root_out,
	output logic [NW-1:0]  num_out,
	output logic [SW-1:0]  side_out
);

	logic [RW+1:0]  t;
	logic [RW+1:0]  trial;
	logic           ge;
	logic [RW-1:0]  rem_q;
	logic [RTW-1:0] root_q;
	logic [NW-1:0]  num_q;
	logic [SW-1:0]  side_q;

	// One root bit per step: bring in two radicand bits, try root*4+1
	assign t     = {rem_in, num_in[NW-1:NW-2]};
	assign trial = (RW+2)'({root_in, 2'b01});
	assign ge    = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? RW'(t - trial) : t[RW-1:0];
			root_q <= {root_in[RTW-2:0], ge};
			num_q  <= {num_in[NW-3:0], 2'b00};
		end
	end

	assign rem_out  = rem_q;
	assign root_out = root_q;
	assign num_out  = num_q;
	assign side_out = side_q;

endmodule

@@ hw/rtl/dielectric_fresnel_reflectance_core.sv @@
// Unpolarized dielectric Fresnel reflectance. Each transfer on the item
// channel carries a signed Q2.14 incident cosine; each transfer on the result
// channel returns the reflected fraction as unsigned Q1.FRAC_BITS_OUT plus a
// flag that is set when total internal reflection forced the result to one.
// The two refractive indices (unsigned Q4.12) sit in APB registers at byte
// addresses 0 (incident side) and 4 (transmitted side); both reset to 1.0 and
// a register holding zero acts as the smallest step. A positive cosine swaps
// the two indices. Write the registers only while no item is in flight.
// Throughput is one item per clock except while the pipeline holds. The
// pipeline is 80 register stages deep: three front stages (saturate/swap,
// squares, n1^2*sin^2), 28 quotient cells for the transmitted sine squared,
// 17 root cells for the transmitted cosine, one product stage, 29 quotient
// cells for the two amplitude ratios in parallel lanes, one squaring stage
// and the output register. The pipeline advances as a whole; it holds only
// while a result sits in the output register and the far side stalls.
module dielectric_fresnel_reflectance_core #(
	parameter int FRAC_BITS_OUT = dfr_pkg::FRAC_BITS_OUT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dfr_pkg::ADDR_W-1:0]        paddr,
	input  logic [dfr_pkg::DATA_W-1:0]        pwdata,
	output logic [dfr_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic signed [dfr_pkg::COS_W-1:0]  cos_incident,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [FRAC_BITS_OUT:0]            reflectance,
	output logic                              total_internal
);

	import dfr_pkg::*;

	localparam int SH = 57 - FRAC_BITS_OUT;
	localparam int RSH_W = FRAC_BITS_OUT + 2;
	localparam logic [FRAC_BITS_OUT:0] ONE_OUT = (FRAC_BITS_OUT+1)'(1) << FRAC_BITS_OUT;
	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SH - 1);
	localparam int SIDE_W = $bits(front_side_t);
	localparam int DIV_N = S2T_W;
	localparam int SQRT_N = ROOT_W;
	localparam int RAT_N = RATIO_W;

	// ---------------- configuration registers ----------------
	logic [IDX_W-1:0] idx_inc_q;
	logic [IDX_W-1:0] idx_trn_q;
	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_inc_q <= INDEX_RESET;
			idx_trn_q <= INDEX_RESET;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(paddr[2]))
				REG_INCIDENT:    idx_inc_q <= pwdata[IDX_W-1:0];
				REG_TRANSMITTED: idx_trn_q <= pwdata[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[2]))
			REG_INCIDENT:    prdata = DATA_W'(idx_inc_q);
			REG_TRANSMITTED: prdata = DATA_W'(idx_trn_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// Advance every stage together unless a finished result is held
	logic adv;
	logic out_v_q;

	assign adv        = !out_v_q || !result_stall;
	assign item_stall = !adv;

	// ---------------- stage 1: magnitude, saturate, swap ----------------
	logic [COS_W-1:0] raw;
	logic [COS_W-1:0] mag16;
	logic [MAG_W-1:0] mag_sat;
	logic             pos;
	logic [IDX_W-1:0] n_inc;
	logic [IDX_W-1:0] n_trn;

	assign raw     = cos_incident;
	assign mag16   = raw[COS_W-1] ? (COS_W'(0) - raw) : raw;
	assign mag_sat = (mag16 > COS_W'(ONE_Q14)) ? ONE_Q14 : mag16[MAG_W-1:0];
	assign pos     = !raw[COS_W-1] && (raw != '0);
	assign n_inc   = (idx_inc_q != '0) ? idx_inc_q : IDX_W'(1);
	assign n_trn   = (idx_trn_q != '0) ? idx_trn_q : IDX_W'(1);

	logic             v_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [IDX_W-1:0] n1_s1;
	logic [IDX_W-1:0] n2_s1;

	// ---------------- stage 2: squares ----------------
	logic [AA_W-1:0]  aa;
	logic             v_s2;
	logic [S2I_W-1:0] s2i_s2;
	logic [SQ_W-1:0]  n1sq_s2;
	logic [SQ_W-1:0]  n2sq_s2;
	logic [MAG_W-1:0] mag_s2;
	logic [IDX_W-1:0] n1_s2;
	logic [IDX_W-1:0] n2_s2;

	assign aa = AA_W'(mag_s1) * AA_W'(mag_s1);

	// ---------------- stage 3: n1^2 * sin_i^2 ----------------
	logic             v_s3;
	logic [LHS_W-1:0] lhs_s3;
	logic [SQ_W-1:0]  n2sq_s3;
	logic [MAG_W-1:0] mag_s3;
	logic [IDX_W-1:0] n1_s3;
	logic [IDX_W-1:0] n2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= mag_sat;
			n1_s1   <= pos ? n_trn : n_inc;
			n2_s1   <= pos ? n_inc : n_trn;

			s2i_s2  <= S2I_W'((AA_W'(1) << Q28) - aa);
			n1sq_s2 <= SQ_W'(n1_s1) * SQ_W'(n1_s1);
			n2sq_s2 <= SQ_W'(n2_s1) * SQ_W'(n2_s1);
			mag_s2  <= mag_s1;
			n1_s2   <= n1_s1;
			n2_s2   <= n2_s1;

			lhs_s3  <= LHS_W'(n1sq_s2) * LHS_W'(s2i_s2);
			n2sq_s3 <= n2sq_s2;
			mag_s3  <= mag_s2;
			n1_s3   <= n1_s2;
			n2_s3   <= n2_s2;
		end
	end

	// ---------------- sin_t^2 quotient cells ----------------
	// Total internal reflection when n1^2 sin_i^2 >= n2^2; otherwise the
	// upper part of the dividend is already below the divisor.
	logic              tir;
	front_side_t       side_in0;
	logic [SQ_W-1:0]   dden [0:DIV_N];
	logic [SQ_W-1:0]   drem [0:DIV_N];
	logic [S2T_W-1:0]  dnum [0:DIV_N];
	logic [S2T_W-1:0]  dquot[0:DIV_N];
	logic [SIDE_W-1:0] dside[0:DIV_N];

	assign tir = lhs_s3 >= {1'b0, n2sq_s3, Q28'(0)};

	always_comb begin
		side_in0.vld = v_s3;
		side_in0.tir = tir;
		side_in0.mag = mag_s3;
		side_in0.n1  = n1_s3;
		side_in0.n2  = n2_s3;
	end

	assign dden[0]  = n2sq_s3;
	assign drem[0]  = lhs_s3[LHS_W-2:Q28];
	assign dnum[0]  = lhs_s3[Q28-1:0];
	assign dquot[0] = '0;
	assign dside[0] = side_in0;

	for (genvar i = 0; i < DIV_N; i++) begin : g_s2t
		dfr_div_cell #(
			.DW(SQ_W), .NW(S2T_W), .QW(S2T_W), .SW(SIDE_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.den_in(dden[i]), .rem_in(drem[i]), .num_in(dnum[i]),
			.quot_in(dquot[i]), .side_in(dside[i]),
			.den_out(dden[i+1]), .rem_out(drem[i+1]), .num_out(dnum[i+1]),
			.quot_out(dquot[i+1]), .side_out(dside[i+1])
		);
	end

	// ---------------- cos_t root cells ----------------
	logic [S2I_W-1:0]      cos2t;
	logic [SQRT_REM_W-1:0] srem [0:SQRT_N];
	logic [ROOT_W-1:0]     sroot[0:SQRT_N];
	logic [SQRT_NUM_W-1:0] snum [0:SQRT_N];
	logic [SIDE_W-1:0]     sside[0:SQRT_N];

	assign cos2t    = S2I_W'((S2I_W'(1) << Q28) - S2I_W'(dquot[DIV_N]));
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign snum[0]  = {1'b0, cos2t, 4'b0000};
	assign sside[0] = dside[DIV_N];

	for (genvar i = 0; i < SQRT_N; i++) begin : g_cos
		dfr_sqrt_cell #(
			.RW(SQRT_REM_W), .RTW(ROOT_W), .NW(SQRT_NUM_W), .SW(SIDE_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.rem_in(srem[i]), .root_in(sroot[i]), .num_in(snum[i]),
			.side_in(sside[i]),
			.rem_out(srem[i+1]), .root_out(sroot[i+1]), .num_out(snum[i+1]),
			.side_out(sside[i+1])
		);
	end

	// ---------------- products ----------------
	front_side_t       fside;
	logic [CI_W-1:0]   ci;
	logic [ROOT_W-1:0] ct;
	logic              v_s4;
	logic              tir_s4;
	logic [PROD_W-1:0] n2ci_s4;
	logic [PROD_W-1:0] n1ct_s4;
	logic [PROD_W-1:0] n1ci_s4;
	logic [PROD_W-1:0] n2ct_s4;

	assign fside = front_side_t'(sside[SQRT_N]);
	assign ci    = {fside.mag, 2'b00};
	assign ct    = sroot[SQRT_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= fside.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tir_s4  <= fside.tir;
			n2ci_s4 <= PROD_W'(fside.n2) * PROD_W'(ci);
			n1ct_s4 <= PROD_W'(fside.n1) * PROD_W'(ct);
			n1ci_s4 <= PROD_W'(fside.n1) * PROD_W'(ci);
			n2ct_s4 <= PROD_W'(fside.n2) * PROD_W'(ct);
		end
	end

	// ---------------- amplitude ratio lanes ----------------
	// |num| << 28 / den, with |num| <= den, split so the first remainder
	// stays below the divisor.
	logic [PROD_W-1:0]  mag_par;
	logic [PROD_W-1:0]  mag_perp;
	logic [DEN_W-1:0]   pden [0:RAT_N];
	logic [DEN_W-1:0]   prem [0:RAT_N];
	logic [RATIO_W-1:0] pnum [0:RAT_N];
	logic [RATIO_W-1:0] pquot[0:RAT_N];
	logic               pside[0:RAT_N];
	logic [DEN_W-1:0]   qden [0:RAT_N];
	logic [DEN_W-1:0]   qrem [0:RAT_N];
	logic [RATIO_W-1:0] qnum [0:RAT_N];
	logic [RATIO_W-1:0] qquot[0:RAT_N];
	logic               qside[0:RAT_N];

	assign mag_par  = (n2ci_s4 >= n1ct_s4) ? (n2ci_s4 - n1ct_s4) : (n1ct_s4 - n2ci_s4);
	assign mag_perp = (n1ci_s4 >= n2ct_s4) ? (n1ci_s4 - n2ct_s4) : (n2ct_s4 - n1ci_s4);

	assign pden[0]  = DEN_W'(n2ci_s4) + DEN_W'(n1ct_s4);
	assign prem[0]  = DEN_W'(mag_par[PROD_W-1:1]);
	assign pnum[0]  = {mag_par[0], Q28'(0)};
	assign pquot[0] = '0;
	assign pside[0] = v_s4;

	assign qden[0]  = DEN_W'(n1ci_s4) + DEN_W'(n2ct_s4);
	assign qrem[0]  = DEN_W'(mag_perp[PROD_W-1:1]);
	assign qnum[0]  = {mag_perp[0], Q28'(0)};
	assign qquot[0] = '0;
	assign qside[0] = tir_s4;

	for (genvar i = 0; i < RAT_N; i++) begin : g_ratio
		dfr_div_cell #(
			.DW(DEN_W), .NW(RATIO_W), .QW(RATIO_W), .SW(1)
		) u_par (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.den_in(pden[i]), .rem_in(prem[i]), .num_in(pnum[i]),
			.quot_in(pquot[i]), .side_in(pside[i]),
			.den_out(pden[i+1]), .rem_out(prem[i+1]), .num_out(pnum[i+1]),
			.quot_out(pquot[i+1]), .side_out(pside[i+1])
		);
		dfr_div_cell #(
			.DW(DEN_W), .NW(RATIO_W), .QW(RATIO_W), .SW(1)
		) u_perp (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.den_in(qden[i]), .rem_in(qrem[i]), .num_in(qnum[i]),
			.quot_in(qquot[i]), .side_in(qside[i]),
			.den_out(qden[i+1]), .rem_out(qrem[i+1]), .num_out(qnum[i+1]),
			.quot_out(qquot[i+1]), .side_out(qside[i+1])
		);
	end

	// ---------------- squares of the ratios ----------------
	localparam logic [RATIO_W-1:0] ONE_Q28 = RATIO_W'(1) << Q28;
	logic [RATIO_W-1:0] rp;
	logic [RATIO_W-1:0] rs;
	logic               v_s5;
	logic               tir_s5;
	logic [RSQ_W-1:0]   rp2_s5;
	logic [RSQ_W-1:0]   rs2_s5;

	assign rp = (pquot[RAT_N] > ONE_Q28) ? ONE_Q28 : pquot[RAT_N];
	assign rs = (qquot[RAT_N] > ONE_Q28) ? ONE_Q28 : qquot[RAT_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= pside[RAT_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tir_s5 <= qside[RAT_N];
			rp2_s5 <= RSQ_W'(rp) * RSQ_W'(rp);
			rs2_s5 <= RSQ_W'(rs) * RSQ_W'(rs);
		end
	end

	// ---------------- sum, round, cap, output register ----------------
	logic [SUM_W-1:0]         sum;
	logic [RSH_W-1:0]         rsh;
	logic [FRAC_BITS_OUT:0]   refl;
	logic [FRAC_BITS_OUT:0]   refl_q;
	logic                     tir_q;

	// The sum of two Q56 squares read as Q57 is their mean
	assign sum  = SUM_W'(rp2_s5) + SUM_W'(rs2_s5) + ROUND_HALF;
	assign rsh  = RSH_W'(sum >> SH);
	assign refl = (rsh > RSH_W'(ONE_OUT)) ? ONE_OUT : rsh[FRAC_BITS_OUT:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			refl_q <= tir_s5 ? ONE_OUT : refl;
			tir_q  <= tir_s5;
		end
	end

	assign result_valid   = out_v_q;
	assign reflectance    = refl_q;
	assign total_internal = tir_q;

endmodule

@@ hw/rtl/dfr_checker.sv @@
`include "dielectric_fresnel_reflectance_core_assert.svh"

module dfr_checker #(
	parameter int FRAC_BITS_OUT = dfr_pkg::FRAC_BITS_OUT_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             result_valid,
	input logic                             result_stall,
	input logic [FRAC_BITS_OUT:0]           reflectance,
	input logic                             total_internal
);

	import dfr_pkg::*;

	localparam logic [FRAC_BITS_OUT:0] ONE_OUT = (FRAC_BITS_OUT+1)'(1) << FRAC_BITS_OUT;

	logic                     res_stalled;
	logic                     res_tir;
	logic [FRAC_BITS_OUT+1:0] res_word;

	assign res_stalled = result_valid && result_stall;
	assign res_tir     = result_valid && total_internal;
	assign res_word    = {reflectance, total_internal};

	// Hold a stalled result
	`DFR_ASSERT_NEXT(a_result_held, res_stalled, result_valid, "result dropped while stalled")
	`DFR_ASSERT_NEXT(a_payload_held, res_stalled, $stable(res_word), "stalled result changed")
	// Total internal reflection returns exactly one
	`DFR_ASSERT(a_tir_one, res_tir |-> reflectance == ONE_OUT, "total internal without one")
	// Reflectance never exceeds one
	`DFR_ASSERT(a_refl_cap, result_valid |-> reflectance <= ONE_OUT, "reflectance above one")

endmodule

bind dielectric_fresnel_reflectance_core dfr_checker #(
	.FRAC_BITS_OUT(FRAC_BITS_OUT)
) u_dfr_checker (.*);

@@ bench/tb_dielectric_fresnel_reflectance_core.sv @@
`timescale 1ns / 100ps

// Scoreboard: holds the expected Fresnel results in arrival order.
class fresnel_scoreboard;
	logic [16:0] refl_q[$];
	logic        tir_q[$];
	int          errors;
	int          checked;
	int          tir_seen;

	function void note_item(logic [16:0] refl, logic tir);
		refl_q.push_back(refl);
		tir_q.push_back(tir);
	endfunction

	function void check_result(logic [16:0] refl, logic tir);
		logic [16:0] want_refl;
		logic        want_tir;
		if (refl_q.size() == 0) begin
			$display("%0t: unexpected result refl=%0d tir=%0b", $time, refl, tir);
			errors++;
			return;
		end
		want_refl = refl_q.pop_front();
		want_tir = tir_q.pop_front();
		checked++;
		if (want_tir)
			tir_seen++;
		if (refl !== want_refl) begin
			$display("%0t: reflectance expected %0d actual %0d", $time, want_refl, refl);
			errors++;
		end
		if (tir !== want_tir) begin
			$display("%0t: total_internal expected %0b actual %0b", $time, want_tir, tir);
			errors++;
		end
	endfunction

	function int pending();
		return refl_q.size();
	endfunction
endclass

module tb_dielectric_fresnel_reflectance_core;
	import dfr_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 80;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic signed [15:0] cos_incident = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [FB:0]       reflectance;
	logic              total_internal;

	// Local copy of the two index registers
	logic [15:0] n_inc = 16'd4096;
	logic [15:0] n_trn = 16'd4096;

	fresnel_scoreboard sb = new();
	bit stall_on = 1'b1;

	always #5 clk = ~clk;

	dielectric_fresnel_reflectance_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall), .cos_incident(cos_incident),
		.result_valid(result_valid), .result_stall(result_stall),
		.reflectance(reflectance), .total_internal(total_internal)
	);

	// Integer square root, floor.
	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] amp_ratio(logic [63:0] p, logic [63:0] q,
			logic [63:0] den);
		logic [63:0] mag;
		mag = (p >= q) ? p - q : q - p;
		return (mag << 28) / den;
	endfunction

	// Compute reflectance and the total internal flag for one cosine.
	task automatic predict_fresnel(input logic [15:0] raw, output logic [16:0] refl,
			output logic tir);
		logic [63:0] a, n1, n2, t, s2i, lhs, rhs, s2t, ct, ci, dpar, dperp, rp, rs, sum, r;
		logic neg, pos;
		neg = raw[15];
		pos = !neg && raw != 0;
		a = neg ? 64'h10000 - raw : raw;
		if (a > 16384)
			a = 16384;
		n1 = n_inc ? n_inc : 1;
		n2 = n_trn ? n_trn : 1;
		if (pos) begin
			t = n1;
			n1 = n2;
			n2 = t;
		end
		s2i = (64'd1 << 28) - a * a;
		lhs = n1 * n1 * s2i;
		rhs = (n2 * n2) << 28;
		tir = 1'b0;
		if (lhs >= rhs) begin
			refl = 17'd1 << FB;
			tir = 1'b1;
			return;
		end
		s2t = lhs / (n2 * n2);
		ct = int_sqrt(((64'd1 << 28) - s2t) << 4);
		ci = a << 2;
		dpar = n2 * ci + n1 * ct;
		dperp = n1 * ci + n2 * ct;
		if (dpar == 0 || dperp == 0) begin
			refl = 17'd1 << FB;
			return;
		end
		rp = amp_ratio(n2 * ci, n1 * ct, dpar);
		rs = amp_ratio(n1 * ci, n2 * ct, dperp);
		if (rp > (64'd1 << 28))
			rp = 64'd1 << 28;
		if (rs > (64'd1 << 28))
			rs = 64'd1 << 28;
		sum = rp * rp + rs * rs;
		r = (sum + (64'd1 << (57 - FB - 1))) >> (57 - FB);
		if (r > (64'd1 << FB))
			r = 64'd1 << FB;
		refl = r[16:0];
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(5, 30);
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	// APB write: setup cycle then access cycle; pready is always high.
	task automatic write_index(input cfg_reg_t sel, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(sel) * 4);
		pwdata <= {16'($urandom_range(0, 65535)), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_INCIDENT)
			n_inc = val;
		else
			n_trn = val;
	endtask

	// Drain all expected results, then let the pipeline settle.
	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Hold the item until the block takes it, then predict.
	task automatic send_cos(input logic [15:0] c, input bit gaps);
		logic [16:0] er;
		logic et;
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_valid <= 1'b1;
		cos_incident <= c;
		do @(posedge clk); while (item_stall);
		predict_fresnel(c, er, et);
		sb.note_item(er, et);
	endtask

	task automatic end_items();
		item_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_cos();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 16'($urandom_range(0, 65535));
		if (k == 1)
			return 16'(16384 - $urandom_range(0, 40));
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic [15:0] rand_index();
		int k;
		k = $urandom_range(0, 7);
		if (k == 0)
			return 16'($urandom_range(0, 65535));
		if (k == 1)
			return 16'($urandom_range(0, 3));
		return 16'($urandom_range(4096, 12288));
	endfunction

	// Sample results; the stall pattern is random with some stall-free stretches.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(reflectance, total_internal);
		if (!stall_on)
			result_stall <= 1'b0;
		else if ($urandom_range(0, 39) == 0)
			result_stall <= 1'b1;
		else if (result_stall)
			result_stall <= ($urandom_range(0, 3) != 0);
		else
			result_stall <= ($urandom_range(0, 4) == 0);
	end

	initial begin
		logic [15:0] dir_cos[] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
			16'h4001, 16'hBFFF, 16'h0001, 16'hFFFF, 16'h2D41, 16'hD2BF, 16'h5555, 16'hAAAA};
		logic [15:0] ext_idx[] = '{16'd0, 16'd1, 16'd65535, 16'd4096, 16'd6144};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset indices: equal sides, grazing gives total internal reflection
		foreach (dir_cos[i])
			send_cos(dir_cos[i], 1'b0);
		end_items();
		wait_idle();

		// Glass-like boundary and extreme index pairs
		write_index(REG_INCIDENT, 16'd4096);
		write_index(REG_TRANSMITTED, 16'd6144);
		foreach (dir_cos[i])
			send_cos(dir_cos[i], 1'b1);
		end_items();
		wait_idle();
		foreach (ext_idx[i]) begin
			write_index(REG_INCIDENT, ext_idx[i]);
			write_index(REG_TRANSMITTED, ext_idx[(i + 2) % ext_idx.size()]);
			for (int j = 0; j < 4; j++)
				send_cos(dir_cos[$urandom_range(0, dir_cos.size() - 1)], 1'b1);
			end_items();
			wait_idle();
		end

		// Random phases with fresh indices; some phases run without gaps
		for (int ph = 0; ph < 16; ph++) begin
			bit gaps;
			gaps = (ph % 4) != 3;
			stall_on = gaps;
			write_index(REG_INCIDENT, rand_index());
			write_index(REG_TRANSMITTED, rand_index());
			for (int j = 0; j < 100; j++)
				send_cos(rand_cos(), gaps);
			end_items();
			wait_idle();
		end
		stall_on = 1'b1;

		if (sb.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("Checked %0d results (%0d total internal) over many index settings.",
			sb.checked, sb.tir_seen);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Drop the run if it hangs.
	initial begin
		#3000000;
		$display("Timeout: run did not finish");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dfr_pkg.sv
hw/rtl/dfr_div_cell.sv
hw/rtl/dfr_sqrt_cell.sv
hw/rtl/dielectric_fresnel_reflectance_core.sv
hw/rtl/dfr_checker.sv
bench/tb_dielectric_fresnel_reflectance_core.sv
